// ===== rtl/round_robin_sleep_scheduler_core_assert.svh =====
// Assertion macros used by the scheduler checker.
`ifndef ROUND_ROBIN_SLEEP_SCHEDULER_CORE_ASSERT_SVH
`define ROUND_ROBIN_SLEEP_SCHEDULER_CORE_ASSERT_SVH

// Same-cycle implication under an active-low reset.
`define RRSS_ASSERT_IMP(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("%m: same-cycle check failed");

// Next-cycle implication under an active-low reset.
`define RRSS_ASSERT_NXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("%m: next-cycle check failed");

`endif

// ===== rtl/rrss_pkg.sv =====
// Types and constants of the round-robin sleep scheduler.
package rrss_pkg;

    localparam int ST_W       = 3;
    localparam int WAKE_W     = 32;
    localparam int MS_W       = 32;
    localparam int FREQ_W     = 21;
    localparam int SLOT_OUT_W = 4;
    localparam int DIV_BASE   = 1000;
    localparam int MUL_W      = 32;
    localparam int DIV_SHIFT  = 38;

    localparam logic [MUL_W-1:0]  DIV_RECIP  = 32'd274877907;
    localparam logic [FREQ_W-1:0] FREQ_RESET = 21'd1000;

    typedef enum logic [ST_W-1:0] {
        TS_FREE    = 3'd0,
        TS_READY   = 3'd1,
        TS_RUNNING = 3'd2,
        TS_WAITING = 3'd3,
        TS_DEAD    = 3'd4
    } task_st_t;

    typedef enum logic [1:0] {
        KIND_YIELD = 2'd0,
        KIND_EXIT  = 2'd1,
        KIND_SLEEP = 2'd2,
        KIND_ADD   = 2'd3
    } kind_t;

    typedef enum logic [3:0] {
        S_IDLE,
        S_ADD_SCAN,
        S_ADD_TAIL,
        S_ADD_LINK,
        S_MARK,
        S_SLEEP,
        S_WALK_CHECK,
        S_WALK_FREE,
        S_FIN_PICK,
        S_FIN_CUR,
        S_RESP
    } state_t;

    typedef enum logic [1:0] {
        DV_IDLE,
        DV_RECIP,
        DV_CHECK,
        DV_DONE
    } div_state_t;

endpackage

// ===== rtl/round_robin_sleep_scheduler_core.sv =====
// Top level of the round-robin task scheduler with sleep.
//
// Channel   Handshake                  Payload
// request   start, busy                kind, sleep_ms, now
// result    done (one-cycle strobe)    prev_slot .. halted_out
// config    cfg_valid, cfg_ready       timer_freq_hz
//
// A request is taken when start is high and busy is low; its result follows on done.
// Add scans the slots for a free one, walks the ring to its tail, then links the new slot in.
// Yield and exit mark the current slot, walk the ring unlinking dead tasks, then switch to the pick if any.
// Sleep adds product, reciprocal and remainder steps on one multiplier; halted requests go straight to done.
// The slot table is one memory; per-slot valid bits give its reset content with no clearing pass.
// The receiver cannot stall, so done lasts one cycle and the block then returns to idle.
module round_robin_sleep_scheduler_core
    import rrss_pkg::*;
#(
    parameter int MAX_TASKS = 16
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  start,
    output logic                  busy,
    input  logic [1:0]            kind,
    input  logic [MS_W-1:0]       sleep_ms,
    input  logic [WAKE_W-1:0]     now,
    output logic                  done,
    output logic [SLOT_OUT_W-1:0] prev_slot,
    output logic [SLOT_OUT_W-1:0] current_slot_out,
    output logic                  switched,
    output logic [SLOT_OUT_W-1:0] new_slot,
    output logic                  table_full,
    output logic                  none_ready,
    output logic                  halted_out,
    input  logic                  cfg_valid,
    output logic                  cfg_ready,
    input  logic [FREQ_W-1:0]     timer_freq_hz
);

    localparam int SW = $clog2(MAX_TASKS);
    localparam int NW = $clog2(2 * MAX_TASKS + 1);
    localparam int WW = ST_W + SW + WAKE_W;

    state_t state_reg, state_next;

    logic              halted_reg, halted_next;
    logic [SW-1:0]     running_reg, running_next;
    logic [FREQ_W-1:0] freq_reg;
    kind_t             kind_reg, kind_next;
    logic [MS_W-1:0]   ms_reg, ms_next;
    logic [WAKE_W-1:0] now_reg, now_next;
    logic [SW-1:0]     cur_reg, cur_next;
    logic [SW-1:0]     prv_reg, prv_next;
    task_st_t          prv_st_reg, prv_st_next;
    logic [SW-1:0]     prv_nx_reg, prv_nx_next;
    logic [WAKE_W-1:0] prv_wk_reg, prv_wk_next;
    logic [NW-1:0]     cnt_reg, cnt_next;
    logic [SW-1:0]     free_reg, free_next;
    logic [SW-1:0]     pick_reg, pick_next;
    logic [SW-1:0]     new_reg, new_next;
    logic              full_reg, full_next;
    logic              none_reg, none_next;

    logic [WW-1:0]        mem [MAX_TASKS];
    logic [MAX_TASKS-1:0] vld_reg;
    logic [WW-1:0]        rd_data_reg;
    logic                 rd_vld_reg;
    logic [SW-1:0]        rd_addr_reg;
    logic                 mem_we;
    logic [SW-1:0]        mem_waddr;
    logic [WW-1:0]        mem_wdata;
    logic                 mem_re;
    logic [SW-1:0]        mem_raddr;

    task_st_t          rd_st;
    logic [SW-1:0]     rd_nx;
    logic [WAKE_W-1:0] rd_wk;

    logic              accept;
    logic              div_start;
    logic              div_done;
    logic [WAKE_W-1:0] div_ticks;

    logic rd_is_cur, rd_runnable, walk_limit, walk_pick, walk_dead, walk_end;
    logic walk_halt, walk_none, scan_hit, scan_last, tail_stop;

    rrss_sleep_div u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .sleep_ms (ms_reg),
        .freq     (freq_reg),
        .done     (div_done),
        .ticks    (div_ticks)
    );

    // Slot table: one write and one read port, write-first on a same-slot collision.
    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            mem[mem_waddr] <= mem_wdata;
        end
    end

    always_ff @(posedge clk)
    begin
        if (mem_re)
        begin
            if (mem_we && (mem_waddr == mem_raddr))
            begin
                rd_data_reg <= mem_wdata;
            end
            else
            begin
                rd_data_reg <= mem[mem_raddr];
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg     <= '0;
            rd_vld_reg  <= 1'b0;
            rd_addr_reg <= '0;
        end
        else
        begin
            if (mem_we)
            begin
                vld_reg[mem_waddr] <= 1'b1;
            end
            if (mem_re)
            begin
                rd_addr_reg <= mem_raddr;
                rd_vld_reg  <= (mem_we && (mem_waddr == mem_raddr)) ? 1'b1
                                                                     : vld_reg[mem_raddr];
            end
        end
    end

    // A slot never written reads as its reset content.
    always_comb
    begin
        if (rd_vld_reg)
        begin
            rd_st = task_st_t'(rd_data_reg[WW-1 -: ST_W]);
            rd_nx = rd_data_reg[WAKE_W +: SW];
            rd_wk = rd_data_reg[WAKE_W-1:0];
        end
        else
        begin
            rd_st = (rd_addr_reg == '0) ? TS_RUNNING : TS_FREE;
            rd_nx = rd_addr_reg;
            rd_wk = '0;
        end
    end

    always_comb
    begin
        accept      = start && (state_reg == S_IDLE);
        rd_is_cur   = rd_addr_reg == cur_reg;
        rd_runnable = (rd_st == TS_READY) || (rd_st == TS_RUNNING) ||
                      ((rd_st == TS_WAITING) && (now_reg >= rd_wk));
        walk_limit  = cnt_reg == NW'(2 * MAX_TASKS);
        walk_pick   = !walk_limit && rd_runnable;
        walk_dead   = !walk_limit && !rd_is_cur && (rd_st == TS_DEAD);
        walk_end    = !walk_limit && rd_is_cur && !rd_runnable;
        walk_halt   = walk_end && (rd_st == TS_DEAD) && (rd_nx == cur_reg);
        walk_none   = walk_limit || (walk_end && !walk_halt);
        scan_hit    = rd_st == TS_FREE;
        scan_last   = rd_addr_reg == SW'(MAX_TASKS - 1);
        tail_stop   = (rd_nx == cur_reg) || (cnt_reg == NW'(MAX_TASKS));
    end

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    if (halted_reg)
                    begin
                        state_next = S_RESP;
                    end
                    else if (kind_t'(kind) == KIND_ADD)
                    begin
                        state_next = S_ADD_SCAN;
                    end
                    else
                    begin
                        state_next = S_MARK;
                    end
                end
            end
            S_ADD_SCAN:
            begin
                if (scan_hit)
                begin
                    state_next = S_ADD_TAIL;
                end
                else if (scan_last)
                begin
                    state_next = S_RESP;
                end
            end
            S_ADD_TAIL:
            begin
                if (tail_stop)
                begin
                    state_next = S_ADD_LINK;
                end
            end
            S_ADD_LINK:
            begin
                state_next = S_RESP;
            end
            S_MARK:
            begin
                state_next = (kind_reg == KIND_SLEEP) ? S_SLEEP : S_WALK_CHECK;
            end
            S_SLEEP:
            begin
                if (div_done)
                begin
                    state_next = S_WALK_CHECK;
                end
            end
            S_WALK_CHECK:
            begin
                if (walk_pick)
                begin
                    state_next = S_FIN_PICK;
                end
                else if (walk_dead)
                begin
                    state_next = S_WALK_FREE;
                end
                else if (walk_halt || walk_none)
                begin
                    state_next = S_RESP;
                end
            end
            S_WALK_FREE:
            begin
                state_next = S_WALK_CHECK;
            end
            S_FIN_PICK:
            begin
                state_next = S_FIN_CUR;
            end
            S_FIN_CUR:
            begin
                state_next = S_RESP;
            end
            S_RESP:
            begin
                state_next = S_IDLE;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_comb
    begin
        halted_next  = halted_reg;
        running_next = running_reg;
        kind_next    = kind_reg;
        ms_next      = ms_reg;
        now_next     = now_reg;
        cur_next     = cur_reg;
        prv_next     = prv_reg;
        prv_st_next  = prv_st_reg;
        prv_nx_next  = prv_nx_reg;
        prv_wk_next  = prv_wk_reg;
        cnt_next     = cnt_reg;
        free_next    = free_reg;
        pick_next    = pick_reg;
        new_next     = new_reg;
        full_next    = full_reg;
        none_next    = none_reg;
        mem_we       = 1'b0;
        mem_waddr    = '0;
        mem_wdata    = '0;
        mem_re       = 1'b0;
        mem_raddr    = '0;
        div_start    = 1'b0;
        case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    kind_next = kind_t'(kind);
                    ms_next   = sleep_ms;
                    now_next  = now;
                    cur_next  = running_reg;
                    cnt_next  = '0;
                    new_next  = '0;
                    full_next = 1'b0;
                    none_next = 1'b0;
                    if (!halted_reg)
                    begin
                        mem_re    = 1'b1;
                        mem_raddr = (kind_t'(kind) == KIND_ADD) ? '0 : running_reg;
                    end
                end
            end
            S_ADD_SCAN:
            begin
                if (scan_hit)
                begin
                    free_next = rd_addr_reg;
                    mem_re    = 1'b1;
                    mem_raddr = cur_reg;
                end
                else if (scan_last)
                begin
                    full_next = 1'b1;
                end
                else
                begin
                    mem_re    = 1'b1;
                    mem_raddr = rd_addr_reg + SW'(1);
                end
            end
            S_ADD_TAIL:
            begin
                if (tail_stop)
                begin
                    mem_we    = 1'b1;
                    mem_waddr = rd_addr_reg;
                    mem_wdata = {rd_st, free_reg, rd_wk};
                end
                else
                begin
                    cnt_next  = cnt_reg + NW'(1);
                    mem_re    = 1'b1;
                    mem_raddr = rd_nx;
                end
            end
            S_ADD_LINK:
            begin
                mem_we    = 1'b1;
                mem_waddr = free_reg;
                mem_wdata = {TS_READY, cur_reg, {WAKE_W{1'b0}}};
                new_next  = free_reg;
            end
            S_MARK:
            begin
                prv_next    = cur_reg;
                prv_st_next = rd_st;
                prv_nx_next = rd_nx;
                prv_wk_next = rd_wk;
                case (kind_reg)
                    KIND_EXIT:
                    begin
                        prv_st_next = TS_DEAD;
                        mem_we      = 1'b1;
                        mem_waddr   = cur_reg;
                        mem_wdata   = {TS_DEAD, rd_nx, rd_wk};
                        mem_re      = 1'b1;
                        mem_raddr   = rd_nx;
                    end
                    KIND_SLEEP:
                    begin
                        prv_st_next = TS_WAITING;
                        div_start   = 1'b1;
                    end
                    default:
                    begin
                        mem_re    = 1'b1;
                        mem_raddr = rd_nx;
                    end
                endcase
            end
            S_SLEEP:
            begin
                if (div_done)
                begin
                    prv_wk_next = now_reg + div_ticks;
                    mem_we      = 1'b1;
                    mem_waddr   = cur_reg;
                    mem_wdata   = {TS_WAITING, prv_nx_reg, now_reg + div_ticks};
                    mem_re      = 1'b1;
                    mem_raddr   = prv_nx_reg;
                end
            end
            S_WALK_CHECK:
            begin
                if (!walk_limit)
                begin
                    cnt_next = cnt_reg + NW'(1);
                end
                if (walk_pick)
                begin
                    pick_next = rd_addr_reg;
                end
                else if (walk_dead)
                begin
                    prv_nx_next = rd_nx;
                    mem_we      = 1'b1;
                    mem_waddr   = prv_reg;
                    mem_wdata   = {prv_st_reg, rd_nx, prv_wk_reg};
                end
                else if (walk_halt)
                begin
                    halted_next = 1'b1;
                end
                else if (walk_none)
                begin
                    none_next = 1'b1;
                end
                else
                begin
                    prv_next    = rd_addr_reg;
                    prv_st_next = rd_st;
                    prv_nx_next = rd_nx;
                    prv_wk_next = rd_wk;
                    mem_re      = 1'b1;
                    mem_raddr   = rd_nx;
                end
            end
            S_WALK_FREE:
            begin
                mem_we    = 1'b1;
                mem_waddr = rd_addr_reg;
                mem_wdata = {TS_FREE, rd_addr_reg, {WAKE_W{1'b0}}};
                mem_re    = 1'b1;
                mem_raddr = prv_nx_reg;
            end
            S_FIN_PICK:
            begin
                mem_we    = 1'b1;
                mem_waddr = pick_reg;
                mem_wdata = {TS_RUNNING, rd_nx, rd_wk};
                mem_re    = 1'b1;
                mem_raddr = cur_reg;
            end
            S_FIN_CUR:
            begin
                running_next = pick_reg;
                if ((rd_st == TS_RUNNING) && (pick_reg != cur_reg))
                begin
                    mem_we    = 1'b1;
                    mem_waddr = cur_reg;
                    mem_wdata = {TS_READY, rd_nx, rd_wk};
                end
            end
            S_RESP:
            begin
            end
            default:
            begin
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= S_IDLE;
            halted_reg  <= 1'b0;
            running_reg <= '0;
            freq_reg    <= FREQ_RESET;
            cnt_reg     <= '0;
            full_reg    <= 1'b0;
            none_reg    <= 1'b0;
        end
        else
        begin
            state_reg   <= state_next;
            halted_reg  <= halted_next;
            running_reg <= running_next;
            cnt_reg     <= cnt_next;
            full_reg    <= full_next;
            none_reg    <= none_next;
            if (cfg_valid && cfg_ready)
            begin
                freq_reg <= timer_freq_hz;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        kind_reg   <= kind_next;
        ms_reg     <= ms_next;
        now_reg    <= now_next;
        cur_reg    <= cur_next;
        prv_reg    <= prv_next;
        prv_st_reg <= prv_st_next;
        prv_nx_reg <= prv_nx_next;
        prv_wk_reg <= prv_wk_next;
        free_reg   <= free_next;
        pick_reg   <= pick_next;
        new_reg    <= new_next;
    end

    assign busy             = state_reg != S_IDLE;
    assign done             = state_reg == S_RESP;
    assign cfg_ready        = 1'b1;
    assign prev_slot        = SLOT_OUT_W'(cur_reg);
    assign current_slot_out = SLOT_OUT_W'(running_reg);
    assign switched         = running_reg != cur_reg;
    assign new_slot         = SLOT_OUT_W'(new_reg);
    assign table_full       = full_reg;
    assign none_ready       = none_reg;
    assign halted_out       = halted_reg;

endmodule

// ===== rtl/rrss_sleep_div.sv =====
// Sleep length unit: wrapped ms*freq product, then a ceiling divide by 1000 on one shared multiplier.
module rrss_sleep_div
    import rrss_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              start,
    input  logic [MS_W-1:0]   sleep_ms,
    input  logic [FREQ_W-1:0] freq,
    output logic              done,
    output logic [WAKE_W-1:0] ticks
);

    div_state_t         state_reg, state_next;
    logic [MUL_W-1:0]   mul_a;
    logic [MUL_W-1:0]   mul_b;
    logic [2*MUL_W-1:0] mul_out;
    logic [MUL_W-1:0]   prod_reg, prod_next;
    logic [MUL_W-1:0]   quot_reg, quot_next;
    logic [WAKE_W-1:0]  ticks_reg, ticks_next;
    logic               rem_nz;

    assign mul_out = (2*MUL_W)'(mul_a) * (2*MUL_W)'(mul_b);
    assign rem_nz  = mul_out[MUL_W-1:0] != prod_reg;
    assign done    = state_reg == DV_DONE;
    assign ticks   = ticks_reg;

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            DV_IDLE:
            begin
                if (start)
                begin
                    state_next = DV_RECIP;
                end
            end
            DV_RECIP:
            begin
                state_next = DV_CHECK;
            end
            DV_CHECK:
            begin
                state_next = DV_DONE;
            end
            DV_DONE:
            begin
                state_next = DV_IDLE;
            end
            default:
            begin
                state_next = DV_IDLE;
            end
        endcase
    end

    always_comb
    begin
        mul_a      = '0;
        mul_b      = '0;
        prod_next  = prod_reg;
        quot_next  = quot_reg;
        ticks_next = ticks_reg;
        case (state_reg)
            DV_IDLE:
            begin
                mul_a = MUL_W'(sleep_ms);
                mul_b = MUL_W'(freq);
                if (start)
                begin
                    prod_next = mul_out[MUL_W-1:0];
                end
            end
            DV_RECIP:
            begin
                mul_a     = prod_reg;
                mul_b     = DIV_RECIP;
                quot_next = MUL_W'(mul_out[2*MUL_W-1:DIV_SHIFT]);
            end
            DV_CHECK:
            begin
                mul_a      = quot_reg;
                mul_b      = MUL_W'(DIV_BASE);
                ticks_next = quot_reg + {{(WAKE_W-1){1'b0}}, rem_nz};
            end
            DV_DONE:
            begin
            end
            default:
            begin
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= DV_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_ff @(posedge clk)
    begin
        prod_reg  <= prod_next;
        quot_reg  <= quot_next;
        ticks_reg <= ticks_next;
    end

endmodule

// ===== rtl/rrss_checker.sv =====
// Port-level checker for the scheduler core and its bind.
`include "round_robin_sleep_scheduler_core_assert.svh"

module rrss_checker
    import rrss_pkg::*;
(
    input logic                  clk,
    input logic                  rst_n,
    input logic                  start,
    input logic                  busy,
    input logic                  done,
    input logic [SLOT_OUT_W-1:0] prev_slot,
    input logic [SLOT_OUT_W-1:0] current_slot_out,
    input logic                  switched,
    input logic [SLOT_OUT_W-1:0] new_slot,
    input logic                  table_full,
    input logic                  none_ready
);

    `RRSS_ASSERT_NXT(a_accept_busy, clk, rst_n, start && !busy, busy)
    `RRSS_ASSERT_IMP(a_full_quiet, clk, rst_n, done && table_full, !switched && !none_ready)
    `RRSS_ASSERT_IMP(a_stay_same, clk, rst_n, done && !switched, prev_slot == current_slot_out)
    `RRSS_ASSERT_IMP(a_add_quiet, clk, rst_n, done && (new_slot != '0), !table_full && !switched)

endmodule

bind round_robin_sleep_scheduler_core rrss_checker u_rrss_checker (
    .clk              (clk),
    .rst_n            (rst_n),
    .start            (start),
    .busy             (busy),
    .done             (done),
    .prev_slot        (prev_slot),
    .current_slot_out (current_slot_out),
    .switched         (switched),
    .new_slot         (new_slot),
    .table_full       (table_full),
    .none_ready       (none_ready)
);
